### rtl/core/vac_pkg.sv
// ----------------------------------------------------------------------------
// vac_pkg: shared types and constants of the vector angle cosine pipeline
// Widths of the operands, step counts of the root and divide pipelines, and
// the side data that follows each word down the pipe.
// ----------------------------------------------------------------------------
package vac_pkg;

    localparam int COMP_W     = 32;          // Q16.16 component
    localparam int NUM_COMP   = 6;
    localparam int IN_W       = COMP_W * NUM_COMP;
    localparam int WIDE_W     = 64;          // squares, sums, magnitudes
    localparam int ROOT_W     = 32;          // normalized root
    localparam int REM_W      = ROOT_W + 2;  // root remainder
    localparam int SQRT_STEPS = ROOT_W;      // one root digit per stage
    localparam int QUO_W      = 31;          // quotient always below 2^31
    localparam int SH_W       = 7;           // ka + kb + 30, at most 92
    localparam int K_W        = 5;           // normalization pairs, 0..31
    localparam int OUT_W      = 32;

    localparam logic [SH_W-1:0]  SH_BIAS = SH_W'(30);
    localparam logic [QUO_W-1:0] ONE_Q30 = QUO_W'(32'h4000_0000);

    // Side data carried beside the arithmetic
    typedef struct packed {
        logic              invalid;   // a zero-length vector
        logic              negative;  // sign of the dot product
        logic [WIDE_W-1:0] mag;       // |dot|
        logic [SH_W-1:0]   sh;        // ka + kb + 30
    } side_t;

    // Digit-recurrence root state
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [WIDE_W-1:0] rad;       // radicand bits still to bring in
    } root_t;

    // Restoring divide state
    typedef struct packed {
        logic [WIDE_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } quo_t;

endpackage

### rtl/core/vac_front.sv
// ----------------------------------------------------------------------------
// vac_front: products, sums and normalization
// Five stages: component products, dot and squared-length sums, sign and
// magnitude, then a coarse and a fine normalization of both squared lengths.
// ----------------------------------------------------------------------------
module vac_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [vac_pkg::IN_W-1:0]         in_data,
    output logic                             out_valid,
    output vac_pkg::side_t                   out_side,
    output logic [vac_pkg::WIDE_W-1:0]       out_na,
    output logic [vac_pkg::WIDE_W-1:0]       out_nb
);

    logic signed [vac_pkg::COMP_W-1:0] ax, ay, az, bx, by, bz;

    logic [4:0] vld_reg;

    // stage 1
    logic        [vac_pkg::WIDE_W-1:0] sq_ax_reg, sq_ay_reg, sq_az_reg;
    logic        [vac_pkg::WIDE_W-1:0] sq_bx_reg, sq_by_reg, sq_bz_reg;
    logic signed [vac_pkg::WIDE_W-1:0] p_x_reg, p_y_reg, p_z_reg;
    // stage 2
    logic        [vac_pkg::WIDE_W-1:0] sa_reg, sb_reg;
    logic signed [vac_pkg::WIDE_W+1:0] dot_reg;
    // stage 3
    logic        [vac_pkg::WIDE_W-1:0] sa3_reg, sb3_reg, mag3_reg;
    logic                              inv3_reg, neg3_reg;
    // stage 4
    logic        [vac_pkg::WIDE_W-1:0] ca_reg, cb_reg, mag4_reg;
    logic [1:0]                        kha_reg, khb_reg;
    logic                              inv4_reg, neg4_reg;
    // stage 5
    logic        [vac_pkg::WIDE_W-1:0] na_reg, nb_reg;
    vac_pkg::side_t                    side_reg;

    logic [vac_pkg::WIDE_W-1:0] ca_next, cb_next, na_next, nb_next;
    logic [1:0]                 kha_next, khb_next;
    logic [2:0]                 kla_next, klb_next;
    logic [vac_pkg::K_W-1:0]    ka, kb;

    assign ax = in_data[31:0];
    assign ay = in_data[63:32];
    assign az = in_data[95:64];
    assign bx = in_data[127:96];
    assign by = in_data[159:128];
    assign bz = in_data[191:160];

    // Coarse step: shift by whole groups of 16 bits
    function automatic logic [1:0] coarse_k(input logic [vac_pkg::WIDE_W-1:0] s);
        logic [1:0] k;
        if (s[63:48] != '0)
            k = 2'd0;
        else if (s[47:32] != '0)
            k = 2'd1;
        else if (s[31:16] != '0)
            k = 2'd2;
        else
            k = 2'd3;
        return k;
    endfunction

    // Fine step: first nonzero bit pair among the top 16 bits
    function automatic logic [2:0] fine_k(input logic [vac_pkg::WIDE_W-1:0] s);
        logic [2:0] k;
        k = 3'd7;
        for (int j = 7; j >= 0; j--)
        begin
            if (s[63-2*j -: 2] != 2'b00)
                k = 3'(j);
        end
        return k;
    endfunction

    always_comb
    begin
        kha_next = coarse_k(sa3_reg);
        khb_next = coarse_k(sb3_reg);
        ca_next  = sa3_reg << {kha_next, 4'b0000};
        cb_next  = sb3_reg << {khb_next, 4'b0000};
        kla_next = fine_k(ca_reg);
        klb_next = fine_k(cb_reg);
        na_next  = ca_reg << {kla_next, 1'b0};
        nb_next  = cb_reg << {klb_next, 1'b0};
        ka       = {kha_reg, kla_next};
        kb       = {khb_reg, klb_next};
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_ax_reg <= $unsigned(vac_pkg::WIDE_W'(ax) * vac_pkg::WIDE_W'(ax));
            sq_ay_reg <= $unsigned(vac_pkg::WIDE_W'(ay) * vac_pkg::WIDE_W'(ay));
            sq_az_reg <= $unsigned(vac_pkg::WIDE_W'(az) * vac_pkg::WIDE_W'(az));
            sq_bx_reg <= $unsigned(vac_pkg::WIDE_W'(bx) * vac_pkg::WIDE_W'(bx));
            sq_by_reg <= $unsigned(vac_pkg::WIDE_W'(by) * vac_pkg::WIDE_W'(by));
            sq_bz_reg <= $unsigned(vac_pkg::WIDE_W'(bz) * vac_pkg::WIDE_W'(bz));
            p_x_reg   <= vac_pkg::WIDE_W'(ax) * vac_pkg::WIDE_W'(bx);
            p_y_reg   <= vac_pkg::WIDE_W'(ay) * vac_pkg::WIDE_W'(by);
            p_z_reg   <= vac_pkg::WIDE_W'(az) * vac_pkg::WIDE_W'(bz);

            sa_reg  <= sq_ax_reg + sq_ay_reg + sq_az_reg;
            sb_reg  <= sq_bx_reg + sq_by_reg + sq_bz_reg;
            dot_reg <= (vac_pkg::WIDE_W+2)'(p_x_reg) + (vac_pkg::WIDE_W+2)'(p_y_reg)
                       + (vac_pkg::WIDE_W+2)'(p_z_reg);

            sa3_reg  <= sa_reg;
            sb3_reg  <= sb_reg;
            inv3_reg <= (sa_reg == '0) || (sb_reg == '0);
            neg3_reg <= dot_reg[vac_pkg::WIDE_W+1];
            mag3_reg <= dot_reg[vac_pkg::WIDE_W+1] ? vac_pkg::WIDE_W'(-dot_reg)
                                                   : vac_pkg::WIDE_W'(dot_reg);

            ca_reg   <= ca_next;
            cb_reg   <= cb_next;
            kha_reg  <= kha_next;
            khb_reg  <= khb_next;
            inv4_reg <= inv3_reg;
            neg4_reg <= neg3_reg;
            mag4_reg <= mag3_reg;

            na_reg            <= na_next;
            nb_reg            <= nb_next;
            side_reg.invalid  <= inv4_reg;
            side_reg.negative <= neg4_reg;
            side_reg.mag      <= mag4_reg;
            side_reg.sh       <= vac_pkg::SH_W'(ka) + vac_pkg::SH_W'(kb) + vac_pkg::SH_BIAS;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_side  = side_reg;
    assign out_na    = na_reg;
    assign out_nb    = nb_reg;

endmodule

### rtl/core/vac_sqrt.sv
// ----------------------------------------------------------------------------
// vac_sqrt: dual integer square root pipeline
// Both normalized squared lengths go through 32 stages, one root digit per
// stage, with the side data riding alongside.
// ----------------------------------------------------------------------------
module vac_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  vac_pkg::side_t                   in_side,
    input  logic [vac_pkg::WIDE_W-1:0]       in_na,
    input  logic [vac_pkg::WIDE_W-1:0]       in_nb,
    output logic                             out_valid,
    output vac_pkg::side_t                   out_side,
    output logic [vac_pkg::ROOT_W-1:0]       out_la,
    output logic [vac_pkg::ROOT_W-1:0]       out_lb
);

    logic [vac_pkg::SQRT_STEPS-1:0] vld_reg;
    vac_pkg::root_t                 a_reg    [vac_pkg::SQRT_STEPS];
    vac_pkg::root_t                 b_reg    [vac_pkg::SQRT_STEPS];
    vac_pkg::side_t                 side_reg [vac_pkg::SQRT_STEPS];

    vac_pkg::root_t a_start, b_start;

    // One digit of the root
    function automatic vac_pkg::root_t root_step(input vac_pkg::root_t cur);
        vac_pkg::root_t            nxt;
        logic [vac_pkg::REM_W+1:0] wide;
        logic [vac_pkg::REM_W+1:0] trial;
        wide  = {cur.rem, cur.rad[63:62]};
        trial = {2'b00, cur.root, 2'b01};
        if (wide >= trial)
        begin
            nxt.rem  = vac_pkg::REM_W'(wide - trial);
            nxt.root = {cur.root[vac_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = vac_pkg::REM_W'(wide);
            nxt.root = {cur.root[vac_pkg::ROOT_W-2:0], 1'b0};
        end
        nxt.rad = cur.rad << 2;
        return nxt;
    endfunction

    assign a_start = '{rem: '0, root: '0, rad: in_na};
    assign b_start = '{rem: '0, root: '0, rad: in_nb};

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[vac_pkg::SQRT_STEPS-2:0], in_valid};
    end

    // Digit stages
    generate
        for (genvar g = 0; g < vac_pkg::SQRT_STEPS; g++)
        begin : g_stage
            if (g == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        a_reg[g]    <= root_step(a_start);
                        b_reg[g]    <= root_step(b_start);
                        side_reg[g] <= in_side;
                    end
                end
            end
            else
            begin : g_next
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        a_reg[g]    <= root_step(a_reg[g-1]);
                        b_reg[g]    <= root_step(b_reg[g-1]);
                        side_reg[g] <= side_reg[g-1];
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[vac_pkg::SQRT_STEPS-1];
    assign out_side  = side_reg[vac_pkg::SQRT_STEPS-1];
    assign out_la    = a_reg[vac_pkg::SQRT_STEPS-1].root;
    assign out_lb    = b_reg[vac_pkg::SQRT_STEPS-1].root;

endmodule

### rtl/core/vac_div.sv
// ----------------------------------------------------------------------------
// vac_div: length product, pipelined divide, clamp and sign
// One stage forms D = LA * LB and the starting remainder, 31 stages give one
// quotient bit each, and the last stage clamps to one and applies the sign.
// ----------------------------------------------------------------------------
module vac_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  vac_pkg::side_t                   in_side,
    input  logic [vac_pkg::ROOT_W-1:0]       in_la,
    input  logic [vac_pkg::ROOT_W-1:0]       in_lb,
    output logic                             out_valid,
    output logic [vac_pkg::OUT_W-1:0]        out_cosine,
    output logic                             out_invalid
);

    localparam int NST = vac_pkg::QUO_W;

    // setup stage
    logic                       vs_reg;
    logic [vac_pkg::WIDE_W-1:0] d0_reg;
    logic [vac_pkg::WIDE_W-1:0] r0_reg;
    logic                       low_reg, neg0_reg, inv0_reg;

    // divide stages
    logic [NST-1:0]             vld_reg;
    vac_pkg::quo_t              q_reg   [NST];
    logic [vac_pkg::WIDE_W-1:0] d_reg   [NST];
    logic [NST-1:0]             neg_reg;
    logic [NST-1:0]             inv_reg;

    // output stage
    logic                       vo_reg;
    logic [vac_pkg::OUT_W-1:0]  cos_reg;
    logic                       invo_reg;

    logic [5:0]                 lsh;
    logic [vac_pkg::WIDE_W-1:0] r0_next;
    vac_pkg::quo_t              q_start;
    logic [vac_pkg::QUO_W-1:0]  q_clamp;
    logic [vac_pkg::OUT_W-1:0]  q_ext;

    // One quotient bit
    function automatic vac_pkg::quo_t div_step(input vac_pkg::quo_t cur,
                                               input logic [vac_pkg::WIDE_W-1:0] d,
                                               input logic nb);
        vac_pkg::quo_t            nxt;
        logic [vac_pkg::WIDE_W:0] shifted;
        logic                     qb;
        shifted = {cur.rem, nb};
        qb      = shifted >= {1'b0, d};
        nxt.rem = qb ? vac_pkg::WIDE_W'(shifted - {1'b0, d}) : vac_pkg::WIDE_W'(shifted);
        nxt.quo = {cur.quo[vac_pkg::QUO_W-2:0], qb};
        return nxt;
    endfunction

    // Starting remainder: the numerator M * 2^sh without its low 31 bits
    always_comb
    begin
        lsh     = 6'(in_side.sh - vac_pkg::SH_W'(31));
        r0_next = (in_side.sh == vac_pkg::SH_BIAS) ? (in_side.mag >> 1)
                                                   : (in_side.mag << lsh);
    end

    assign q_start = '{rem: r0_reg, quo: '0};

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg  <= 1'b0;
            vld_reg <= '0;
            vo_reg  <= 1'b0;
        end
        else if (en)
        begin
            vs_reg  <= in_valid;
            vld_reg <= {vld_reg[NST-2:0], vs_reg};
            vo_reg  <= vld_reg[NST-1];
        end
    end

    // Setup stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg   <= vac_pkg::WIDE_W'(in_la) * vac_pkg::WIDE_W'(in_lb);
            r0_reg   <= r0_next;
            low_reg  <= (in_side.sh == vac_pkg::SH_BIAS) && in_side.mag[0];
            neg0_reg <= in_side.negative;
            inv0_reg <= in_side.invalid;
        end
    end

    // Divide stages
    generate
        for (genvar g = 0; g < NST; g++)
        begin : g_stage
            if (g == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        q_reg[g]   <= div_step(q_start, d0_reg, low_reg);
                        d_reg[g]   <= d0_reg;
                        neg_reg[g] <= neg0_reg;
                        inv_reg[g] <= inv0_reg;
                    end
                end
            end
            else
            begin : g_next
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        q_reg[g]   <= div_step(q_reg[g-1], d_reg[g-1], 1'b0);
                        d_reg[g]   <= d_reg[g-1];
                        neg_reg[g] <= neg_reg[g-1];
                        inv_reg[g] <= inv_reg[g-1];
                    end
                end
            end
        end
    endgenerate

    // Clamp to one, apply sign
    always_comb
    begin
        q_clamp = (q_reg[NST-1].quo > vac_pkg::ONE_Q30) ? vac_pkg::ONE_Q30
                                                         : q_reg[NST-1].quo;
        q_ext   = {1'b0, q_clamp};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            invo_reg <= inv_reg[NST-1];
            if (inv_reg[NST-1])
                cos_reg <= '0;
            else if (neg_reg[NST-1])
                cos_reg <= -q_ext;
            else
                cos_reg <= q_ext;
        end
    end

    assign out_valid   = vo_reg;
    assign out_cosine  = cos_reg;
    assign out_invalid = invo_reg;

endmodule

### rtl/core/vector_angle_cosine.sv
// ----------------------------------------------------------------------------
// vector_angle_cosine: cosine of the angle between two 3D vectors
// dot(a,b) / (|a| * |b|) as signed Q2.30, clamped to [-1, 1]; a zero-length
// vector gives zero with the invalid flag set.
//
//   channel   dir   tdata                               tuser
//   s_axis    in    a_x,a_y,a_z,b_x,b_y,b_z (192 bits)  -
//   m_axis    out   cosine (32 bits)                    invalid
//
// One word per cycle unless the output stalls; the pipe has 5 product/sum/
// normalize stages, 32 root stages (one digit each), 33 divide stages.
// The whole pipe advances together; it holds while a result waits and
// m_axis_tready is low, and s_axis_tready follows that same enable.
// Reset clears the valid bits only; no state is kept between words.
// ----------------------------------------------------------------------------
module vector_angle_cosine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [vac_pkg::IN_W-1:0]     s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [vac_pkg::OUT_W-1:0]    m_axis_tdata,   // cosine
    output logic [0:0]                   m_axis_tuser    // invalid
);

    logic                             en;
    logic                             f_valid, r_valid;
    vac_pkg::side_t                   f_side, r_side;
    logic [vac_pkg::WIDE_W-1:0]       f_na, f_nb;
    logic [vac_pkg::ROOT_W-1:0]       r_la, r_lb;
    logic                             d_invalid;

    // Global advance: move unless the output word is stuck
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    vac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_na    (f_na),
        .out_nb    (f_nb)
    );

    vac_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_na     (f_na),
        .in_nb     (f_nb),
        .out_valid (r_valid),
        .out_side  (r_side),
        .out_la    (r_la),
        .out_lb    (r_lb)
    );

    vac_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (r_valid),
        .in_side     (r_side),
        .in_la       (r_la),
        .in_lb       (r_lb),
        .out_valid   (m_axis_tvalid),
        .out_cosine  (m_axis_tdata),
        .out_invalid (d_invalid)
    );

    assign m_axis_tuser = d_invalid;

`ifndef SYNTH
    // A flagged word carries a zero cosine
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("invalid word with nonzero cosine");

    // Cosine stays within [-1, 1]
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= $signed(32'sh4000_0000)) &&
                          ($signed(m_axis_tdata) >= $signed(-32'sh4000_0000)))
        else $error("cosine out of range");

    // A held result blocks new input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // During a stall the pipe does not move: the output word stays
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output changed during stall");
`endif

endmodule
